FILE: rtl/mvm_pkg.sv
// shared types, constants and control structs for the matrix-vector multiply core
package mvm_pkg;

    localparam int DEFAULT_MAX_SIZE = 1024;
    localparam int RESET_SIZE       = 1024;
    localparam int CFG_W            = 11;
    localparam int VALUE_W          = 32;
    localparam int ROW_IDX_W        = 10;
    localparam int ACC_W            = 64;
    localparam int FRAC_BITS        = 16;

    typedef enum logic {
        CMD_LOAD_VECTOR = 1'b0,
        CMD_MATRIX_ELEM = 1'b1
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t                  cmd;
        logic signed [VALUE_W-1:0]  value;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  row_sum;
        logic [ROW_IDX_W-1:0]       row_index;
        logic                       last_row;
    } out_item_t;

    typedef struct packed {
        logic load_we;
        logic mat_capture;
        logic mul_en;
        logic acc_en;
        logic row_end;
    } dp_ctrl_t;

    typedef struct packed {
        logic last_col;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/mvm_controller.sv
// control state machine sequencing vector loads and matrix multiply-accumulate steps
module mvm_controller
    import mvm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  cmd_code_t  s_cmd,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_ctrl_t   ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ACC
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        ctrl       = '0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_cmd == CMD_LOAD_VECTOR) begin
                        ctrl.load_we = 1'b1;
                    end else begin
                        ctrl.mat_capture = 1'b1;
                        state_next       = S_MUL;
                    end
                end
            end
            S_MUL: begin
                ctrl.mul_en = 1'b1;
                state_next  = S_ACC;
            end
            S_ACC: begin
                if (!status.last_col) begin
                    ctrl.acc_en = 1'b1;
                    state_next  = S_IDLE;
                end else if (status.out_free) begin
                    ctrl.acc_en  = 1'b1;
                    ctrl.row_end = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/mvm_datapath.sv
// vector store, counters, multiplier, accumulator and result register
module mvm_datapath
    import mvm_pkg::*;
#(
    parameter int MAX_SIZE = DEFAULT_MAX_SIZE
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    input  in_item_t           s_data,
    input  dp_ctrl_t           ctrl,
    output dp_status_t         status,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data
);

    localparam int IDX_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int SIZE_W = $clog2(MAX_SIZE + 1);
    localparam int CMP_W  = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;
    localparam int RST_EFF = (RESET_SIZE > MAX_SIZE) ? MAX_SIZE : RESET_SIZE;
    localparam logic [IDX_W-1:0] RST_SIZE_M1 = IDX_W'(RST_EFF - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    logic [VALUE_W-1:0] vec_mem [MAX_SIZE];

    logic [IDX_W-1:0]          size_m1_reg;
    logic [IDX_W-1:0]          size_m1_next;
    logic [IDX_W-1:0]          load_idx_reg;
    logic [IDX_W-1:0]          col_reg;
    logic [IDX_W-1:0]          row_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [VALUE_W-1:0] mat_reg;
    logic signed [VALUE_W-1:0] vec_reg;
    logic signed [ACC_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]   prod_next;
    logic                      out_valid_reg;
    out_item_t                 out_data_reg;
    out_item_t                 out_data_next;
    logic [CMP_W-1:0]          cfg_ext;
    logic [CMP_W-1:0]          eff_size;
    logic [31:0]               row_wide;

    // effective size: zero acts as one, clamp to the store depth
    always_comb begin
        cfg_ext = CMP_W'(cfg_wr_data);
        if (cfg_ext == '0) begin
            eff_size = CMP_W'(1);
        end else if (cfg_ext > CMP_W'(MAX_SIZE)) begin
            eff_size = CMP_W'(MAX_SIZE);
        end else begin
            eff_size = cfg_ext;
        end
        size_m1_next = IDX_W'(eff_size - CMP_W'(1));
    end

    assign status.last_col = (col_reg == size_m1_reg);
    assign status.out_free = !out_valid_reg || m_ready;

    assign prod_next = mat_reg * vec_reg;
    assign acc_next  = acc_reg + (prod_reg >>> FRAC_BITS);
    assign row_wide  = 32'(row_reg);

    always_comb begin
        if (acc_next > SAT_MAX) begin
            out_data_next.row_sum = SAT_MAX[VALUE_W-1:0];
        end else if (acc_next < SAT_MIN) begin
            out_data_next.row_sum = SAT_MIN[VALUE_W-1:0];
        end else begin
            out_data_next.row_sum = acc_next[VALUE_W-1:0];
        end
        out_data_next.row_index = row_wide[ROW_IDX_W-1:0];
        out_data_next.last_row  = (row_reg == size_m1_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_we) begin
            vec_mem[load_idx_reg] <= s_data.value;
        end
        if (ctrl.mat_capture) begin
            vec_reg <= vec_mem[col_reg];
            mat_reg <= s_data.value;
        end
        if (ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
        if (ctrl.row_end) begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_m1_reg   <= RST_SIZE_M1;
            load_idx_reg  <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                size_m1_reg  <= size_m1_next;
                load_idx_reg <= '0;
                col_reg      <= '0;
                row_reg      <= '0;
                acc_reg      <= '0;
            end else begin
                if (ctrl.load_we) begin
                    load_idx_reg <= (load_idx_reg == size_m1_reg) ? '0 :
                                    load_idx_reg + IDX_W'(1);
                end
                if (ctrl.acc_en) begin
                    if (ctrl.row_end) begin
                        acc_reg <= '0;
                        col_reg <= '0;
                        row_reg <= (row_reg == size_m1_reg) ? '0 : row_reg + IDX_W'(1);
                    end else begin
                        acc_reg <= acc_next;
                        col_reg <= col_reg + IDX_W'(1);
                    end
                end
            end
            if (ctrl.row_end) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

FILE: rtl/matrix_vector_multiply_core.sv
// top level of the Q16.16 dense matrix-vector multiply core
// usage:
//   write matrix_size through cfg_wr_en/cfg_wr_data while idle; a write also
//   clears the load index, column and row counters and the accumulator.
//   send n vector elements (cmd load) on s_*, then the n x n matrix row-major
//   (cmd matrix). one transaction on m_* follows each completed row with the
//   saturated row sum, its row index and a last-row flag.
// timing:
//   a vector load is written to the store when accepted; a matrix element goes
//   through the store read, the registered 32x32 multiply and the 64-bit
//   accumulate steps; a row's last accumulate step registers its sum on m_*.
//   the result register lets loads and earlier elements of the next row be
//   taken while a row sum waits; when the receiver stalls, the final element
//   of the next row holds in the accumulate step until m_ready frees the slot.
// reset:
//   aresetn is synchronous, active low; matrix_size returns to 1024 (capped to
//   MAX_SIZE), counters and accumulator clear, the vector store keeps its data
//   and its entries are undefined until loaded.
module matrix_vector_multiply_core
    import mvm_pkg::*;
#(
    parameter int MAX_SIZE = DEFAULT_MAX_SIZE
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    dp_ctrl_t   ctrl;
    dp_status_t status;

    mvm_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_data.cmd),
        .s_ready (s_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    mvm_datapath #(
        .MAX_SIZE (MAX_SIZE)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .ctrl        (ctrl),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

`ifndef SYNTHESIS
    // a row sum never overwrites one that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.row_end |-> (!m_valid || m_ready))
        else $error("row sum written while result slot busy");

    // a matrix element keeps the input closed while it is multiplied
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.cmd == CMD_MATRIX_ELEM) |=> !s_ready)
        else $error("input accepted during multiply step");

    // the multiply step always follows a matrix capture
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.mul_en |-> $past(ctrl.mat_capture))
        else $error("multiply without captured operands");
`endif

endmodule
